/* sv/pph_pkg.sv */
// Shared constants, request codes and store interface type for the packed pixel histogram.
package pph_pkg;

    localparam int PIX_W   = 8;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 32;
    localparam int ADDR_W  = 8;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [COUNT_W-1:0] wr_data;
        logic               clr;
    } t_store_req;

endpackage

/* sv/packed_pixel_histogram.sv */
// Packed pixel histogram top level: request sequencer, read-modify-write and readout register.
// A pixel request latches the word, then looks up the bin of each pixel slot in turn through the
// single read port of the bin memory, then retires the last write; back-to-back updates of the
// same bin are forwarded. A readout request reads the bin memory, then captures the count into
// the output register, and is held off while an earlier result still waits downstream; pixel
// requests are taken meanwhile. The final bin of a readout run clears all counts at once through
// the valid bits; no clearing pass follows reset.
module packed_pixel_histogram
    import pph_pkg::*;
#(
    parameter int NUM_BINS        = 256,
    parameter int PIXELS_PER_WORD = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [WORD_W-1:0]  i_pixel_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_bin_index,
    output logic [COUNT_W-1:0] o_bin_count,
    output logic               o_last_bin
);

    localparam int AW = $clog2(NUM_BINS);
    localparam int KW = (PIXELS_PER_WORD > 1) ? $clog2(PIXELS_PER_WORD) : 1;
    localparam logic [KW-1:0] K_LAST   = KW'(PIXELS_PER_WORD - 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(NUM_BINS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PIX   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_RD    = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [WORD_W-1:0]  r_word;
    logic [KW-1:0]      r_k, n_k;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pa, n_pa;
    logic [AW-1:0]      r_ridx, n_ridx;
    logic               r_fw_en;
    logic [AW-1:0]      r_fw_addr;
    logic [COUNT_W-1:0] r_fw_data;
    logic               r_out_valid;
    logic [AW-1:0]      r_out_idx;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_last;

    t_store_req           store_req;
    logic [COUNT_W-1:0]   rd_count;
    logic [2*WORD_W-1:0]  word_ext;
    logic [2*WORD_W-1:0]  word_sh;
    logic [PIX_W-1:0]     px;
    logic                 px_ok;
    logic [AW-1:0]        px_addr;
    logic [COUNT_W-1:0]   base;
    logic [COUNT_W-1:0]   inc;
    logic                 accept;
    logic                 out_take;

    pph_bin_store #(
        .NUM_BINS(NUM_BINS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rd_count (rd_count)
    );

    assign o_in_stall = (r_state != S_IDLE)
                      || (i_req_type == REQ_READ && r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    assign word_ext = {WORD_W'(0), r_word};
    assign word_sh  = word_ext >> {3'(r_k), 3'b000};
    assign px       = word_sh[PIX_W-1:0];
    assign px_ok    = 9'(px) < 9'(NUM_BINS);
    assign px_addr  = px[AW-1:0];

    // take the value written last cycle when it hits the bin now being updated
    assign base = (r_fw_en && r_fw_addr == r_pa) ? r_fw_data : rd_count;
    assign inc  = base + COUNT_W'(1);

    always_comb begin
        n_state           = r_state;
        n_k               = r_k;
        n_pend            = r_pend;
        n_pa              = r_pa;
        n_ridx            = r_ridx;
        store_req         = '0;
        store_req.wr_addr = ADDR_W'(r_pa);
        store_req.wr_data = inc;
        case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (accept) begin
                    if (i_req_type == REQ_READ) begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = ADDR_W'(r_ridx);
                        n_state           = S_RD;
                    end else begin
                        n_k     = '0;
                        n_state = S_PIX;
                    end
                end
            end
            S_PIX: begin
                store_req.wr_en   = r_pend;
                store_req.rd_en   = px_ok;
                store_req.rd_addr = ADDR_W'(px_addr);
                n_pend            = px_ok;
                n_pa              = px_addr;
                if (r_k == K_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = KW'(r_k + 1'b1);
                end
            end
            S_DRAIN: begin
                store_req.wr_en = r_pend;
                n_pend          = 1'b0;
                n_state         = S_IDLE;
            end
            S_RD: begin
                n_state = S_IDLE;
                if (r_ridx == IDX_LAST) begin
                    store_req.clr = 1'b1;
                    n_ridx        = '0;
                end else begin
                    n_ridx = AW'(r_ridx + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_ridx      <= '0;
            r_fw_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pend  <= n_pend;
            r_ridx  <= n_ridx;
            r_fw_en <= store_req.wr_en;
            if (r_state == S_RD) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa      <= n_pa;
        r_fw_addr <= r_pa;
        r_fw_data <= inc;
        if (r_state == S_IDLE && accept) begin
            r_word <= i_pixel_word;
        end
        if (r_state == S_RD) begin
            r_out_idx  <= r_ridx;
            r_out_cnt  <= rd_count;
            r_out_last <= (r_ridx == IDX_LAST);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_index = 8'(r_out_idx);
    assign o_bin_count = r_out_cnt;
    assign o_last_bin  = r_out_last;

endmodule

/* sv/pph_bin_store.sv */
// Bin count memory with per-entry valid bits and a registered read.
module pph_bin_store
    import pph_pkg::*;
#(
    parameter int NUM_BINS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_store_req         i_req,
    output logic [COUNT_W-1:0] o_rd_count
);

    localparam int AW = $clog2(NUM_BINS);

    logic [COUNT_W-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_vld;
    logic [COUNT_W-1:0] r_q;
    logic               r_q_vld;
    logic [AW-1:0]      rd_a;
    logic [AW-1:0]      wr_a;

    assign rd_a = i_req.rd_addr[AW-1:0];
    assign wr_a = i_req.wr_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_a] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q     <= r_mem[rd_a];
            r_q_vld <= r_vld[rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[wr_a] <= 1'b1;
        end
    end

    assign o_rd_count = r_q_vld ? r_q : '0;

endmodule

/* sv/pph_checker.sv */
// Port-level checks for the packed pixel histogram, bound to the top level.
module pph_checker
    import pph_pkg::*;
#(
    parameter int NUM_BINS = 256
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_req_type,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [7:0]         o_bin_index,
    input logic [COUNT_W-1:0] o_bin_count,
    input logic               o_last_bin
);

    localparam logic [7:0] LAST_IDX = 8'(NUM_BINS - 1);

    logic in_acc;
    logic rd_acc;

    assign in_acc = i_in_valid && !o_in_stall;
    assign rd_acc = in_acc && i_req_type == REQ_READ;

    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> ##1 o_out_valid)
        else $error("readout request gave no result");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(rd_acc, 2))
        else $error("result without a readout request");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_bin |-> o_bin_index == LAST_IDX)
        else $error("last bin flagged on wrong index");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request taken while previous request in progress");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bin_count)
            && $stable(o_bin_index) && $stable(o_last_bin))
        else $error("stalled result changed");

endmodule

bind packed_pixel_histogram pph_checker #(
    .NUM_BINS(NUM_BINS)
) u_pph_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_bin_index (o_bin_index),
    .o_bin_count (o_bin_count),
    .o_last_bin  (o_last_bin)
);
